>>> hw/rtl/cce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC engine package
// Shared types, register indexes, width codes and bit helpers.
// ----------------------------------------------------------------------------
package cce_pkg;

	localparam int CRC_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;

	// width_mode codes
	localparam logic [1:0] MODE_W7  = 2'd0;
	localparam logic [1:0] MODE_W8  = 2'd1;
	localparam logic [1:0] MODE_W16 = 2'd2;
	localparam logic [1:0] MODE_W32 = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_VALUE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT_INPUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUTPUT = 3'd4;

	// reset values
	localparam logic [1:0]       RST_WIDTH_MODE  = MODE_W32;
	localparam logic [CRC_W-1:0] RST_POLYNOMIAL  = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] RST_START_VALUE = 32'h0000_0000;

	typedef struct packed {
		logic [1:0]       width_mode;
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] start_value;
		logic             reflect_input;
		logic             reflect_output;
	} cfg_t;

	function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] mode);
		logic [CRC_W-1:0] m;
		case (mode)
			MODE_W7:  m = 32'h0000_007F;
			MODE_W8:  m = 32'h0000_00FF;
			MODE_W16: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [CRC_W-1:0] top_bit(input logic [1:0] mode);
		logic [CRC_W-1:0] t;
		case (mode)
			MODE_W7:  t = 32'h0000_0040;
			MODE_W8:  t = 32'h0000_0080;
			MODE_W16: t = 32'h0000_8000;
			default:  t = 32'h8000_0000;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15-i];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/cce_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC engine stream interfaces
// Byte input channel and CRC result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cce_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cce_crc_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink   (input valid, input crc_value, output ready);
endinterface

>>> hw/rtl/cce_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC engine configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cce_cfg_regs import cce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CRC_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_mode     <= RST_WIDTH_MODE;
			cfg_q.polynomial     <= RST_POLYNOMIAL;
			cfg_q.start_value    <= RST_START_VALUE;
			cfg_q.reflect_input  <= 1'b0;
			cfg_q.reflect_output <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH_MODE:     cfg_q.width_mode     <= wr_data[1:0];
				REG_POLYNOMIAL:     cfg_q.polynomial     <= wr_data;
				REG_START_VALUE:    cfg_q.start_value    <= wr_data;
				REG_REFLECT_INPUT:  cfg_q.reflect_input  <= wr_data[0];
				REG_REFLECT_OUTPUT: cfg_q.reflect_output <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/cce_byte_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC engine byte update
// Folds one byte into the running CRC and forms the finished result.
// ----------------------------------------------------------------------------
module cce_byte_update import cce_pkg::*; (
	input  cfg_t              cfg,
	input  logic [CRC_W-1:0]  crc_in,
	input  logic              msg_start,
	input  logic [BYTE_W-1:0] data,
	output logic [CRC_W-1:0]  crc_next,
	output logic [CRC_W-1:0]  crc_result
);

	logic [CRC_W-1:0]  mask;
	logic [CRC_W-1:0]  top;
	logic [CRC_W-1:0]  base;
	logic [BYTE_W-1:0] b;
	logic [CRC_W-1:0]  x;

	assign mask = width_mask(cfg.width_mode);
	assign top  = top_bit(cfg.width_mode);
	assign base = (msg_start ? cfg.start_value : crc_in) & mask;
	assign b    = cfg.reflect_input ? rev8(data) : data;

	always_comb begin
		case (cfg.width_mode)
			MODE_W16: x = base ^ {16'd0, b, 8'd0};
			MODE_W32: x = base ^ {b, 24'd0};
			default:  x = base ^ {24'd0, b};
		endcase
		// eight shift steps, MSB first
		for (int j = 0; j < 8; j++) begin
			if ((x & top) != '0) begin
				x = (x << 1) ^ cfg.polynomial;
			end else begin
				x = x << 1;
			end
		end
		crc_next = x & mask;
	end

	always_comb begin
		crc_result = crc_next;
		if (cfg.reflect_output) begin
			case (cfg.width_mode)
				MODE_W7, MODE_W8: crc_result = {24'd0, rev8(crc_next[7:0])};
				MODE_W16:         crc_result = {16'd0, rev16(crc_next[15:0])};
				default:          crc_result = crc_next;
			endcase
		end
	end

endmodule

>>> hw/rtl/configurable_crc_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configurable CRC engine
// Bytewise MSB-first CRC of width 7, 8, 16 or 32 with programmable polynomial.
// ----------------------------------------------------------------------------
// The engine takes one message byte per clock on byte_in, unless a last byte
// is held back by a full result register, and on the byte marked last_byte
// returns the finished CRC on crc_out. An input register holds each byte,
// eight unrolled shift steps fold it into the running CRC register, and the
// result register takes the CRC of a last byte, which is offered on crc_out
// from there. Bytes that are not last keep flowing while a result waits on
// crc_out; a last byte waits in the input register until the result register
// is free. The start value is loaded at the first byte of each message.
// Write the configuration only while the engine is idle.
// ----------------------------------------------------------------------------
module configurable_crc_engine_unit import cce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CRC_W-1:0]     wr_data,
	cce_byte_if.sink             byte_in,
	cce_crc_if.source            crc_out
);

	cfg_t cfg;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	// running state
	logic [CRC_W-1:0] crc_q;
	logic             msg_start_q;

	// result register
	logic             out_valid_q;
	logic [CRC_W-1:0] out_crc_q;

	logic [CRC_W-1:0] crc_next;
	logic [CRC_W-1:0] crc_result;
	logic             out_free;
	logic             fire_s1;
	logic             accept;

	cce_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	cce_byte_update u_update (
		.cfg        (cfg),
		.crc_in     (crc_q),
		.msg_start  (msg_start_q),
		.data       (data_s1),
		.crc_next   (crc_next),
		.crc_result (crc_result)
	);

	// The result slot is free if empty or drained this cycle.
	assign out_free = !out_valid_q || crc_out.ready;
	// A byte in the input stage retires unless it is last and the slot is full.
	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign byte_in.ready = !valid_s1 || fire_s1;
	assign accept   = byte_in.valid && byte_in.ready;

	// Load the input stage; drop its valid once the byte retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	// Advance the running CRC; a last byte re-arms the start value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			msg_start_q <= 1'b1;
		end else if (fire_s1) begin
			crc_q       <= crc_next;
			msg_start_q <= last_s1;
		end
	end

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (crc_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_crc_q <= crc_result;
		end
	end

	assign crc_out.valid     = out_valid_q;
	assign crc_out.crc_value = out_crc_q;

	// A last byte always lands a result.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> out_valid_q)
		else $error("last byte retired without a result");

	// The message start flag follows the last mark of the retired byte.
	a_start_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> msg_start_q == $past(last_s1))
		else $error("message start flag out of step");

	// The running CRC never carries bits above the configured width.
	a_crc_masked: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> (crc_q & ~width_mask(cfg.width_mode)) == '0)
		else $error("running CRC exceeds width");

	// A full result slot that is not drained blocks a last byte.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !crc_out.ready |-> !(fire_s1 && last_s1))
		else $error("result overwritten before it was taken");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC engine testbench
// Streams message bytes into the engine under changing width, polynomial,
// start value and reflection settings, and checks each finished CRC against
// a bit-accurate predictor kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
	import cce_pkg::*;

	// Index that maps to no register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	// Cycles to let pass once every expected CRC has arrived: a byte that is
	// not last leaves no trace on the output but may still sit in the engine.
	localparam int DRAIN_CYCLES = 6;
	// Length of the long receiver hold-off that backs up the pipeline.
	localparam int HOLD_CYCLES  = 250;
	localparam int TARGET_ITEMS = 1950;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the configuration and the running CRC, predicts the
	// finished CRC of each message and matches it against the output.
	// ------------------------------------------------------------------------
	class crc_checker;
		logic [1:0]  width_mode;
		logic [31:0] poly;
		logic [31:0] seed;
		logic        flip_in;
		logic        flip_out;
		logic [31:0] running;
		logic        opening;
		logic [31:0] crc_expected[$];
		int          errors;
		int          reported;

		function new();
			width_mode = RST_WIDTH_MODE;
			poly       = RST_POLYNOMIAL;
			seed       = RST_START_VALUE;
			flip_in    = 1'b0;
			flip_out   = 1'b0;
			running    = '0;
			opening    = 1'b1;
			errors     = 0;
			reported   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				REG_WIDTH_MODE:     width_mode = val[1:0];
				REG_POLYNOMIAL:     poly       = val;
				REG_START_VALUE:    seed       = val;
				REG_REFLECT_INPUT:  flip_in    = val[0];
				REG_REFLECT_OUTPUT: flip_out   = val[0];
				default: ;
			endcase
		endfunction

		// Reverse the low n bits of v; bits above n come back as zero.
		function logic [31:0] mirror(logic [31:0] v, int n);
			logic [31:0] r;
			int          i;
			r = '0;
			for (i = 0; i < n; i++) begin
				r[n-1-i] = v[i];
			end
			return r;
		endfunction

		// Fold one accepted byte into the running CRC; queue the CRC on a last byte.
		function void take_byte(logic [7:0] data, logic last);
			logic [31:0] acc;
			logic [31:0] msk;
			logic [31:0] topb;
			logic [7:0]  b;
			int          sh;
			int          j;
			case (width_mode)
				MODE_W7: begin
					msk = 32'h0000_007F; topb = 32'h0000_0040; sh = 0;
				end
				MODE_W8: begin
					msk = 32'h0000_00FF; topb = 32'h0000_0080; sh = 0;
				end
				MODE_W16: begin
					msk = 32'h0000_FFFF; topb = 32'h0000_8000; sh = 8;
				end
				default: begin
					msk = 32'hFFFF_FFFF; topb = 32'h8000_0000; sh = 24;
				end
			endcase
			// The start value is picked up only at the first byte of a message;
			// mid-message the old register is cut down to the current width.
			acc = (opening ? seed : running) & msk;
			b   = flip_in ? 8'(mirror({24'd0, data}, 8)) : data;
			acc = acc ^ ({24'd0, b} << sh);
			for (j = 0; j < 8; j++) begin
				if ((acc & topb) != 0) begin
					acc = (acc << 1) ^ poly;
				end else begin
					acc = acc << 1;
				end
			end
			acc     = acc & msk;
			running = acc;
			opening = last;
			if (last) begin
				if (flip_out) begin
					// 7-bit CRCs reflect as a byte, so they land in bits 7..1.
					if (width_mode == MODE_W7 || width_mode == MODE_W8) begin
						acc = mirror(acc, 8);
					end else if (width_mode == MODE_W16) begin
						acc = mirror(acc, 16);
					end
				end
				crc_expected.push_back(acc);
			end
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (reported < 10) begin
				reported++;
				$display("%0t ns: %s: expected %08h, actual %08h", $time, what, want, got);
			end
		endfunction

		function void match_crc(logic [31:0] got);
			logic [31:0] want;
			if (crc_expected.size() == 0) begin
				flag("crc_value with no message pending", 'x, got);
			end else begin
				want = crc_expected.pop_front();
				if (got !== want) begin
					flag("crc_value", want, got);
				end
			end
		endfunction

		function int pending();
			return crc_expected.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, channels and the engine
	// ------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CRC_W-1:0]     wr_data;

	cce_byte_if byte_ch ();
	cce_crc_if  crc_ch ();

	crc_checker chk = new();

	// Shared by the sender and the receiver: calm drops all idling for a
	// stretch, hold_req asks the receiver for one long hold-off.
	bit calm     = 1'b0;
	bit hold_req = 1'b0;
	int items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	configurable_crc_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.byte_in  (byte_ch),
		.crc_out  (crc_ch)
	);

	// ------------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------------

	// Mostly back-to-back, often a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Byte values lean toward the all-zero and all-one extremes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h0000_0001 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	// Called at a falling edge with valid possibly still high from the last
	// item. Lower valid only if a gap follows, so valid is never dropped and
	// raised in the same step. Returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] data, input logic last, input int gap);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.last_byte <= last;
		do begin
			@(posedge clk);
		end while (byte_ch.ready !== 1'b1);
		chk.take_byte(data, last);
		items_sent++;
		@(negedge clk);
	endtask

	// Send len random bytes; mark the final one last only if close is set,
	// which leaves the message open across the next configuration change.
	task automatic send_run(input int len, input bit close);
		int i;
		for (i = 0; i < len; i++) begin
			send_byte(pick_byte(), close && (i == len - 1), pick_gap());
		end
	endtask

	// Drop valid, wait for every queued CRC, then let in-flight bytes drain.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (chk.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One register write: enable high for one rising edge, then low again.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		chk.write_reg(idx, val);
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Draw a new setting for a phase; width is redrawn three times in four, the
	// rest half the time. Upper data bits of narrow registers are random.
	task automatic shuffle_config();
		if ($urandom_range(0, 3) != 0) begin
			write_reg(REG_WIDTH_MODE, $urandom());
		end
		if ($urandom_range(0, 1) != 0) begin
			write_reg(REG_POLYNOMIAL, pick_word());
		end
		if ($urandom_range(0, 1) != 0) begin
			write_reg(REG_START_VALUE, pick_word());
		end
		if ($urandom_range(0, 1) != 0) begin
			write_reg(REG_REFLECT_INPUT, $urandom());
		end
		if ($urandom_range(0, 1) != 0) begin
			write_reg(REG_REFLECT_OUTPUT, $urandom());
		end
		if ($urandom_range(0, 15) == 0) begin
			write_reg(REG_UNMAPPED, $urandom());
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: sample at the rising edge, check against the scoreboard
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && crc_ch.valid === 1'b1 && crc_ch.ready === 1'b1) begin
			chk.match_crc(crc_ch.crc_value);
		end
	end

	// Receiver ready: random stalls, or one long hold-off on request. The
	// hold-off is counted here while the sender keeps offering bytes.
	initial begin : receiver
		int stall_left;
		stall_left   = 0;
		crc_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				crc_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				crc_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				crc_ch.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int phase;
		int budget;
		int len;
		bit close;

		// Every input known from time zero; hold reset, then release it at a falling edge.
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_WIDTH_MODE;
		wr_data           = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---------------------------------------------------
		// Reset settings: 32-bit, standard polynomial, zero start, no reflection.
		send_byte(8'h00, 1'b1, 0);
		send_byte(8'hFF, 1'b1, 0);

		// Open a 32-bit message, go idle, narrow to 16 bits, finish it.
		send_byte(8'hA5, 1'b0, 1);
		send_byte(8'h5A, 1'b0, 0);
		settle();
		write_reg(REG_WIDTH_MODE, {30'd0, MODE_W16});
		send_byte(8'h3C, 1'b1, 0);

		// 7-bit width: bit 7 of a byte has no effect; start all ones.
		settle();
		write_reg(REG_WIDTH_MODE, {30'd0, MODE_W7});
		write_reg(REG_POLYNOMIAL, 32'h0000_0009);
		write_reg(REG_START_VALUE, 32'hFFFF_FFFF);
		send_byte(8'h80, 1'b1, 0);
		send_byte(8'h00, 1'b1, 0);
		send_byte(8'hFF, 1'b1, 0);

		// 7-bit with both reflections: result moves up to bits 7..1.
		settle();
		write_reg(REG_REFLECT_INPUT, 32'd1);
		write_reg(REG_REFLECT_OUTPUT, 32'd1);
		send_byte(8'h01, 1'b1, 2);
		send_byte(8'h7F, 1'b1, 0);

		// 8-bit, output reflected, then plain.
		settle();
		write_reg(REG_WIDTH_MODE, {30'd0, MODE_W8});
		write_reg(REG_POLYNOMIAL, 32'h0000_0007);
		write_reg(REG_START_VALUE, 32'h0000_00FF);
		write_reg(REG_REFLECT_INPUT, 32'd0);
		send_byte(8'h31, 1'b0, 0);
		send_byte(8'h32, 1'b1, 0);
		settle();
		write_reg(REG_REFLECT_OUTPUT, 32'd0);
		send_byte(8'h31, 1'b1, 0);

		// 16-bit with both reflections.
		settle();
		write_reg(REG_WIDTH_MODE, {30'd0, MODE_W16});
		write_reg(REG_POLYNOMIAL, 32'h0000_1021);
		write_reg(REG_START_VALUE, 32'h0000_FFFF);
		write_reg(REG_REFLECT_INPUT, 32'd1);
		write_reg(REG_REFLECT_OUTPUT, 32'd1);
		send_byte(8'h00, 1'b0, 0);
		send_byte(8'hFF, 1'b1, 0);

		// 32-bit extremes: all-one polynomial and start; output reflection
		// must leave a 32-bit result alone.
		settle();
		write_reg(REG_WIDTH_MODE, {30'd0, MODE_W32});
		write_reg(REG_POLYNOMIAL, 32'hFFFF_FFFF);
		write_reg(REG_START_VALUE, 32'hFFFF_FFFF);
		write_reg(REG_REFLECT_INPUT, 32'd0);
		send_byte(8'hFF, 1'b1, 0);

		// Zero polynomial and start; a write to an unmapped index changes nothing.
		settle();
		write_reg(REG_POLYNOMIAL, 32'h0000_0000);
		write_reg(REG_START_VALUE, 32'h0000_0000);
		write_reg(REG_REFLECT_OUTPUT, 32'd0);
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		send_byte(8'h80, 1'b0, 0);
		send_byte(8'h01, 1'b1, 0);

		// --- random part -----------------------------------------------------
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			phase++;
			settle();
			shuffle_config();
			if (phase % 9 == 3) begin
				// Back the engine up: receiver holds off while short messages
				// stream in without gaps, until the input stalls.
				calm     = 1'b1;
				hold_req = 1'b1;
				repeat (30) send_run($urandom_range(1, 2), 1'b1);
				calm = 1'b0;
			end else begin
				calm   = ($urandom_range(0, 4) == 0);
				budget = $urandom_range(20, 80);
				while (budget > 0) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					                                  : $urandom_range(1, 8);
					if (len > budget) begin
						len = budget;
					end
					// The final run of a phase may stay open across the
					// next configuration change.
					close = (len < budget) || ($urandom_range(0, 1) != 0);
					send_run(len, close);
					budget -= len;
				end
			end
		end

		// --- wind down -------------------------------------------------------
		settle();
		if (chk.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
